// ===== sv/jops_pkg.sv =====
// Shared types and constants for the JSON object pair splitter.
package jops_pkg;

  localparam int unsigned MAX_DEPTH_DEF   = 255;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_QUOTE,
    CLS_COLON,
    CLS_COMMA,
    CLS_LBRACE,
    CLS_RBRACE,
    CLS_LBRACK,
    CLS_RBRACK
  } char_class_e;

  typedef enum logic [2:0] {
    PH_SEEK_OBJ,
    PH_SEEK_KEY,
    PH_KEY,
    PH_SEEK_COLON,
    PH_VALUE,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_KEY,
    KIND_VALUE,
    KIND_PAIR,
    KIND_CLOSE
  } kind_e;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic        end_of_text;
    char_class_e cls;
  } tok_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic       depth_overflow;
  } res_t;

endpackage

// ===== sv/jops_fifo.sv =====
// Small register-based queue used between the splitter stages.
module jops_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push_ok, pop_ok;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_ok, pop_ok})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_ok && !pop_ok) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on push");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_ok && !push_ok) |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count did not shrink on pop");

endmodule

// ===== sv/jops_front.sv =====
// Front end: classifies incoming text bytes and queues them for the parser.
module jops_front #(
  parameter int unsigned QUEUE_DEPTH = jops_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     text_byte_i,
  input  logic           end_of_text_i,
  input  logic           tok_pop_i,
  output jops_pkg::tok_t tok_o,
  output logic           tok_empty_o
);
  import jops_pkg::*;

  tok_t                 tok_in;
  char_class_e          cls;
  logic [$bits(tok_t)-1:0] tok_vec;

  always_comb begin
    case (text_byte_i)
      CH_QUOTE:  cls = CLS_QUOTE;
      CH_COLON:  cls = CLS_COLON;
      CH_COMMA:  cls = CLS_COMMA;
      CH_LBRACE: cls = CLS_LBRACE;
      CH_RBRACE: cls = CLS_RBRACE;
      CH_LBRACK: cls = CLS_LBRACK;
      CH_RBRACK: cls = CLS_RBRACK;
      default:   cls = CLS_OTHER;
    endcase
    tok_in.text_byte   = text_byte_i;
    tok_in.end_of_text = end_of_text_i;
    tok_in.cls         = cls;
  end

  jops_fifo #(
    .WIDTH($bits(tok_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_tok_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (tok_in),
    .full_o (full),
    .pop_i  (tok_pop_i),
    .data_o (tok_vec),
    .empty_o(tok_empty_o)
  );

  assign tok_o = tok_t'(tok_vec);

endmodule

// ===== sv/jops_back.sv =====
// Back end: pair/value parser state machine and result queue.
module jops_back #(
  parameter int unsigned MAX_DEPTH   = jops_pkg::MAX_DEPTH_DEF,
  parameter int unsigned QUEUE_DEPTH = jops_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jops_pkg::tok_t tok_i,
  input  logic           tok_empty_i,
  output logic           tok_pop_o,
  input  logic           pop,
  output logic           empty,
  output logic [1:0]     kind_o,
  output logic [7:0]     data_byte_o,
  output logic           depth_overflow_o
);
  import jops_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam logic [DW-1:0] MAX_D = DW'(MAX_DEPTH);

  phase_e          phase_q, phase_d;
  logic [DW-1:0]   depth_q, depth_d;
  logic            instr_q, instr_d;
  logic            ovf_q, ovf_d;
  logic            res_full, step, emit;
  res_t            res;
  logic [$bits(res_t)-1:0] res_vec;
  res_t            res_out;
  logic            is_open, is_close;

  assign step      = !tok_empty_i && !res_full;
  assign tok_pop_o = step;
  assign is_open   = (tok_i.cls == CLS_LBRACE) || (tok_i.cls == CLS_LBRACK);
  assign is_close  = (tok_i.cls == CLS_RBRACE) || (tok_i.cls == CLS_RBRACK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK_OBJ;
      depth_q <= '0;
      instr_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      depth_q <= depth_d;
      instr_q <= instr_d;
      ovf_q   <= ovf_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    depth_d  = depth_q;
    instr_d  = instr_q;
    ovf_d    = ovf_q;
    emit     = 1'b0;
    res.kind = KIND_VALUE;
    res.data_byte = CH_NUL;
    if (step) begin
      case (phase_q)
        PH_SEEK_OBJ: begin
          if (tok_i.cls == CLS_LBRACE) phase_d = PH_SEEK_KEY;
        end
        PH_SEEK_KEY: begin
          if (tok_i.cls == CLS_QUOTE) begin
            phase_d = PH_KEY;
          end else if (tok_i.cls == CLS_RBRACE) begin
            phase_d  = PH_DONE;
            emit     = 1'b1;
            res.kind = KIND_CLOSE;
          end
        end
        PH_KEY: begin
          if (tok_i.cls == CLS_QUOTE) begin
            phase_d = PH_SEEK_COLON;
          end else begin
            emit          = 1'b1;
            res.kind      = KIND_KEY;
            res.data_byte = tok_i.text_byte;
          end
        end
        PH_SEEK_COLON: begin
          if (tok_i.cls == CLS_COLON) begin
            phase_d = PH_VALUE;
            depth_d = '0;
            instr_d = 1'b0;
          end else if (tok_i.cls == CLS_RBRACE) begin
            phase_d  = PH_DONE;
            emit     = 1'b1;
            res.kind = KIND_CLOSE;
          end
        end
        PH_VALUE: begin
          emit = 1'b1;
          if (instr_q) begin
            if (tok_i.cls == CLS_QUOTE) instr_d = 1'b0;
            res.data_byte = tok_i.text_byte;
          end else if (depth_q == '0 && tok_i.cls == CLS_COMMA) begin
            phase_d  = PH_SEEK_KEY;
            res.kind = KIND_PAIR;
          end else if (depth_q == '0 && tok_i.cls == CLS_RBRACE) begin
            phase_d  = PH_DONE;
            res.kind = KIND_CLOSE;
          end else begin
            res.data_byte = tok_i.text_byte;
            if (tok_i.cls == CLS_QUOTE) begin
              instr_d = 1'b1;
            end else if (is_open) begin
              // saturate at the top and remember it
              if (depth_q >= MAX_D) ovf_d = 1'b1;
              else depth_d = depth_q + 1'b1;
            end else if (is_close) begin
              if (depth_q != '0) depth_d = depth_q - 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (tok_i.end_of_text) begin
        phase_d = PH_SEEK_OBJ;
        depth_d = '0;
        instr_d = 1'b0;
      end
    end
    res.depth_overflow = ovf_d;
  end

  jops_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (emit),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_vec),
    .empty_o(empty)
  );

  assign res_out          = res_t'(res_vec);
  assign kind_o           = res_out.kind;
  assign data_byte_o      = res_out.data_byte;
  assign depth_overflow_o = res_out.depth_overflow;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= MAX_D)
    else $error("nesting depth beyond limit");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

  a_string_in_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    instr_q |-> phase_q == PH_VALUE)
    else $error("in-string flag outside a value");

  a_depth_in_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (depth_q != '0) |-> phase_q == PH_VALUE)
    else $error("nonzero depth outside a value");

endmodule

// ===== sv/json_object_pair_splitter.sv =====
// Top level of the JSON top-level key/value splitter.
//
//  channel  direction  handshake                 payload
//  text     in         push / full               text_byte_i, end_of_text_i
//  result   out        empty / pop               kind_o, data_byte_o, depth_overflow_o
//
// One text byte per cycle sustained while the result queue is not full; each byte gives zero or one result.
// A pushed byte is stored in the byte queue, parsed from there by the back end, and its
// result is stored in the result queue, from which it shows on the result ports.
// The back-end parser state machine takes a byte whenever one waits and the result queue is not full.
// Reset is asynchronous and empties both queues; there is no clearing pass.
// With pop held low the result queue fills, then the byte queue, then full rises.
module json_object_pair_splitter #(
  parameter int unsigned MAX_DEPTH   = jops_pkg::MAX_DEPTH_DEF,
  parameter int unsigned QUEUE_DEPTH = jops_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  input  logic       pop,
  output logic       empty,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic       depth_overflow_o
);
  import jops_pkg::*;

  tok_t tok;
  logic tok_empty;
  logic tok_pop;

  jops_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .tok_pop_i    (tok_pop),
    .tok_o        (tok),
    .tok_empty_o  (tok_empty)
  );

  jops_back #(
    .MAX_DEPTH  (MAX_DEPTH),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tok_i           (tok),
    .tok_empty_i     (tok_empty),
    .tok_pop_o       (tok_pop),
    .pop             (pop),
    .empty           (empty),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .depth_overflow_o(depth_overflow_o)
  );

endmodule
